/* sv/hsv_to_rgb_assert.svh */
// Assertion macros shared by the hsv_to_rgb RTL.
// No dependencies; included by files that check their own pipeline logic.
`ifndef HSV_TO_RGB_ASSERT_SVH
`define HSV_TO_RGB_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define HSVR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define HSVR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define HSVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/hsvr_pkg.sv */
// Shared constants, types and helpers for the HSV to RGB converter.
// No dependencies; used by hsvr_quant and hsv_to_rgb.
package hsvr_pkg;

  // Pipeline depth, input register to output register
  localparam int NUM_STAGES = 7;

  // Offset that lifts any 17-bit hue to a positive value (3 turns of 23040)
  localparam logic [17:0] HUE_OFFSET = 18'd69120;
  // One 60 degree sector in 1/64 degree units
  localparam logic [11:0] SECTOR_LEN = 12'd3840;
  // ceil(2^16 / 15): exact floor(x/15) for x below 4096
  localparam logic [12:0] RECIP15 = 13'd4370;
  // 43 / 256 gives exact floor(q/6) for q below 36
  localparam logic [5:0] RECIP6 = 6'd43;
  // Full-scale channel numerator, 65536 * 3840
  localparam logic [27:0] NUM_MAX = 28'd251658240;

  // Hue sectors, named by the colors they span
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;
  localparam logic [2:0] SEC_MAG_RED = 3'd5;

  // Stage loads for the quantizer tail of the pipeline
  typedef struct packed {
    logic adv_sum;
    logic adv_byte;
  } quant_ctl_t;

  // Clamp a signed 10-bit unit value to 0..256
  function automatic logic [8:0] clamp_unit(input logic [9:0] x);
    logic [8:0] res;
    if (x[9]) begin
      res = 9'd0;
    end else if (x[8:0] > 9'd256) begin
      res = 9'd256;
    end else begin
      res = x[8:0];
    end
    return res;
  endfunction

endpackage

/* sv/hsvr_quant.sv */
// Two-stage rounding of one channel numerator to an 8-bit level.
// Depends on hsvr_pkg (constants, quant_ctl_t).
module hsvr_quant (
  input  logic               clk,
  input  hsvr_pkg::quant_ctl_t ctl,
  input  logic [27:0]        num,
  output logic [7:0]         level
);

  logic [36:0] scaled;
  logic [11:0] tsum;
  logic [24:0] prod;
  logic [8:0]  quo;

  // 510*N + D, then drop the power-of-two part of 2*D
  assign scaled = ({9'd0, num} << 9) - ({9'd0, num} << 1) + 37'(hsvr_pkg::NUM_MAX);

  always_ff @(posedge clk) begin
    if (ctl.adv_sum) begin
      tsum <= scaled[36:25];
    end
  end

  // Remaining divide by 15 through the reciprocal
  assign prod = 25'(tsum) * 25'(hsvr_pkg::RECIP15);
  assign quo  = prod[24:16];

  // Clamp and hold the level
  always_ff @(posedge clk) begin
    if (ctl.adv_byte) begin
      level <= (quo > 9'd255) ? 8'hFF : quo[7:0];
    end
  end

endmodule

/* sv/hsv_to_rgb.sv */
// HSV to 8-bit RGB converter, top level: hue decode, products, channel select.
// Depends on hsvr_pkg, hsvr_quant and hsv_to_rgb_assert.svh.
//
//  Bus   Dir  Width  Beat contents
//  s_*   in   40     hue, saturation, brightness
//  m_*   out  24     red, green, blue
//
// Seven register stages; a beat taken on s_* moves through them in order to m_*.
// One pixel per clock unless m_* stalls; each stage holds its own valid bit.
// Ready runs back stage by stage, so bubbles close up during an output stall.
// Reset clears the valid bits only; data registers are not reset.
`include "hsv_to_rgb_assert.svh"

module hsv_to_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [16:0] hue, [26:17] saturation, [36:27] brightness
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

  localparam int NSTG = hsvr_pkg::NUM_STAGES;

  logic [NSTG:1]   vld;
  logic [NSTG:1]   vld_in;
  logic [NSTG+1:1] rdy;

  // Stage 1: clamped unit values and lifted hue
  logic [17:0] u1;
  logic [8:0]  sat1, val1;
  // Stage 2: sector count and chroma product
  logic [22:0] qprod;
  logic [5:0]  q2;
  logic [17:0] u2;
  logic [16:0] vs2;
  logic [8:0]  val2;
  // Stage 3: sector, ramp and offset terms
  logic [17:0] q3840, udiff;
  logic [11:0] frac;
  logic [10:0] qd;
  logic [2:0]  qd6;
  logic [4:0]  six_qd6;
  logic [5:0]  sec_full;
  logic [2:0]  sec_w;
  logic [2:0]  sec3;
  logic [11:0] g3;
  logic [16:0] vs3, d3;
  // Stage 4: chroma, ramp and offset numerators
  logic [28:0] nx_w, nc_w, nm_w;
  logic [27:0] nc4, nx4, nm4;
  logic [2:0]  sec4;
  // Stage 5: channel numerators
  logic [27:0] cv, xv;
  logic [27:0] n5 [3];
  logic [7:0]  level [3];

  hsvr_pkg::quant_ctl_t qctl;

  // Ready chain: a stage can load when it is empty or its successor loads
  always_comb begin
    rdy[NSTG+1] = m_tready;
    for (int i = NSTG; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign vld_in   = {vld[NSTG-1:1], s_tvalid};
  assign s_tready = rdy[1];
  assign m_tvalid = vld[NSTG];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 1; i <= NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // Stage 1: clamp and lift hue
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      u1   <= {s_tdata[16], s_tdata[16:0]} + hsvr_pkg::HUE_OFFSET;
      sat1 <= hsvr_pkg::clamp_unit(s_tdata[26:17]);
      val1 <= hsvr_pkg::clamp_unit(s_tdata[36:27]);
    end
  end

  // Stage 2: count whole sectors (divide by 256 then by 15), form V*S
  assign qprod = 23'(u1[17:8]) * 23'(hsvr_pkg::RECIP15);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      q2   <= qprod[21:16];
      u2   <= u1;
      vs2  <= 17'(sat1) * 17'(val1);
      val2 <= val1;
    end
  end

  // Stage 3: in-sector offset, sector modulo six, ramp direction
  assign q3840    = {q2, 12'd0} - {4'd0, q2, 8'd0};
  assign udiff    = u2 - q3840;
  assign frac     = udiff[11:0];
  assign qd       = 11'(q2) * 11'(hsvr_pkg::RECIP6);
  assign qd6      = qd[10:8];
  assign six_qd6  = {qd6, 2'b00} + {1'b0, qd6, 1'b0};
  assign sec_full = q2 - {1'b0, six_qd6};
  assign sec_w    = sec_full[2:0];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sec3 <= sec_w;
      g3   <= sec_w[0] ? (hsvr_pkg::SECTOR_LEN - frac) : frac;
      vs3  <= vs2;
      d3   <= {val2, 8'd0} - vs2;
    end
  end

  // Stage 4: numerators over D = 65536 * 3840
  assign nx_w = 29'(vs3) * 29'(g3);
  assign nc_w = {vs3, 12'd0} - {4'd0, vs3, 8'd0};
  assign nm_w = {d3, 12'd0} - {4'd0, d3, 8'd0};

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      nx4  <= nx_w[27:0];
      nc4  <= nc_w[27:0];
      nm4  <= nm_w[27:0];
      sec4 <= sec3;
    end
  end

  // Stage 5: add the offset and permute by sector
  assign cv = nc4 + nm4;
  assign xv = nx4 + nm4;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      case (sec4)
        hsvr_pkg::SEC_RED_YEL: begin
          n5[0] <= cv;  n5[1] <= xv;  n5[2] <= nm4;
        end
        hsvr_pkg::SEC_YEL_GRN: begin
          n5[0] <= xv;  n5[1] <= cv;  n5[2] <= nm4;
        end
        hsvr_pkg::SEC_GRN_CYN: begin
          n5[0] <= nm4; n5[1] <= cv;  n5[2] <= xv;
        end
        hsvr_pkg::SEC_CYN_BLU: begin
          n5[0] <= nm4; n5[1] <= xv;  n5[2] <= cv;
        end
        hsvr_pkg::SEC_BLU_MAG: begin
          n5[0] <= xv;  n5[1] <= nm4; n5[2] <= cv;
        end
        default: begin
          n5[0] <= cv;  n5[1] <= nm4; n5[2] <= xv;
        end
      endcase
    end
  end

  // Stages 6 and 7: round each channel
  assign qctl.adv_sum  = rdy[6];
  assign qctl.adv_byte = rdy[7];

  for (genvar k = 0; k < 3; k++) begin : g_chan
    hsvr_quant u_quant (
      .clk   (clk),
      .ctl   (qctl),
      .num   (n5[k]),
      .level (level[k])
    );
  end

  assign m_tdata = {level[2], level[1], level[0]};

  // Checks on pipeline control and arithmetic ranges
  `HSVR_ASSERT_NEXT(a_take_fills_s1, clk, rst, s_tvalid && s_tready, vld[1],
                    "beat taken but stage 1 empty")
  `HSVR_ASSERT_IMPL(a_full_stall, clk, rst, (&vld) && !m_tready, !s_tready,
                    "full pipeline took a beat during stall")
  `HSVR_ASSERT_IMPL(a_sector_range, clk, rst, vld[3],
                    (sec3 <= hsvr_pkg::SEC_MAG_RED) && (g3 <= hsvr_pkg::SECTOR_LEN),
                    "sector or ramp out of range")
  `HSVR_ASSERT_IMPL(a_ramp_below_chroma, clk, rst, vld[4], nx4 <= nc4,
                    "ramp term exceeds chroma")
  `HSVR_ASSERT_IMPL(a_num_full_scale, clk, rst, vld[5],
                    (n5[0] <= hsvr_pkg::NUM_MAX) && (n5[1] <= hsvr_pkg::NUM_MAX)
                    && (n5[2] <= hsvr_pkg::NUM_MAX),
                    "channel numerator above full scale")

endmodule

/* bench/hsv_to_rgb_test.sv */
// Self-checking bench for hsv_to_rgb: directed and random HSV pixels,
// random stalls on both buses; scores every RGB beat against an integer model.
// Depends on hsvr_pkg and the hsv_to_rgb RTL.
module hsv_to_rgb_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HUE_TURN     = 23040;
  localparam int SECTOR_SPAN  = 3840;
  localparam int LEVEL_FULL   = 256;
  localparam longint unsigned CHAN_SCALE = 64'd251658240;
  localparam int RANDOM_PIXELS = 1200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_WAIT     = 19;

  typedef struct packed {
    logic signed [9:0]  brightness;
    logic signed [9:0]  saturation;
    logic signed [16:0] hue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Expected colors of accepted pixels, oldest first
  class rgb_tracker;
    rgb_t expected_rgb[$];
    int   mismatches;
    int   checked;

    function int clamp_level(input logic signed [9:0] x);
      int t;
      t = x;
      if (t < 0) return 0;
      if (t > LEVEL_FULL) return LEVEL_FULL;
      return t;
    endfunction

    // Round half up from the exact ratio n / CHAN_SCALE, saturate at 255
    function logic [7:0] to_byte(input longint unsigned n);
      longint unsigned q;
      q = (510 * n + CHAN_SCALE) / (2 * CHAN_SCALE);
      if (q > 255) q = 255;
      return q[7:0];
    endfunction

    function rgb_t predict_rgb(input pixel_t px);
      int h, s, v;
      int unsigned f, g;
      logic [2:0] sector;
      longint unsigned full_v, chroma, x_part, base, c_ch, x_ch;
      rgb_t res;
      // wrap hue to one turn, true modulo
      h = int'(px.hue) % HUE_TURN;
      if (h < 0) h += HUE_TURN;
      s = clamp_level(px.saturation);
      v = clamp_level(px.brightness);
      sector = 3'(h / SECTOR_SPAN);
      f = h % SECTOR_SPAN;
      g = sector[0] ? SECTOR_SPAN - f : f;
      full_v = longint'(v) * LEVEL_FULL * SECTOR_SPAN;
      chroma = longint'(v) * longint'(s) * SECTOR_SPAN;
      x_part = longint'(v) * longint'(s) * g;
      base = full_v - chroma;
      c_ch = chroma + base;
      x_ch = x_part + base;
      case (sector)
        hsvr_pkg::SEC_RED_YEL:
          res = '{blue: to_byte(base), green: to_byte(x_ch), red: to_byte(c_ch)};
        hsvr_pkg::SEC_YEL_GRN:
          res = '{blue: to_byte(base), green: to_byte(c_ch), red: to_byte(x_ch)};
        hsvr_pkg::SEC_GRN_CYN:
          res = '{blue: to_byte(x_ch), green: to_byte(c_ch), red: to_byte(base)};
        hsvr_pkg::SEC_CYN_BLU:
          res = '{blue: to_byte(c_ch), green: to_byte(x_ch), red: to_byte(base)};
        hsvr_pkg::SEC_BLU_MAG:
          res = '{blue: to_byte(c_ch), green: to_byte(base), red: to_byte(x_ch)};
        default:
          res = '{blue: to_byte(x_ch), green: to_byte(base), red: to_byte(c_ch)};
      endcase
      return res;
    endfunction

    function void note_pixel(input pixel_t px);
      expected_rgb.push_back(predict_rgb(px));
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_rgb(input rgb_t got);
      rgb_t want;
      checked++;
      if (expected_rgb.size() == 0) begin
        report_mismatch($sformatf("unexpected beat r=%0d g=%0d b=%0d",
                                  got.red, got.green, got.blue));
        return;
      end
      want = expected_rgb.pop_front();
      if (got.red !== want.red)
        report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
      if (got.green !== want.green)
        report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  rgb_tracker tracker = new();
  int cycles;
  int sent;
  int directed_count;

  hsv_to_rgb i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one pixel after a random gap, hold it until taken
  task automatic send_pixel(input pixel_t px, input bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(MAX_WAIT, 0);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, px};
    do @(posedge clk); while (!s_tready);
    tracker.note_pixel(px);
    sent++;
  endtask

  task automatic send_hsv(input int h, input int s, input int v);
    pixel_t px;
    px.hue        = 17'(h);
    px.saturation = 10'(s);
    px.brightness = 10'(v);
    send_pixel(px, 1'b0);
  endtask

  // Mostly in-range levels and one-turn hues, with a share of full-range noise
  function automatic pixel_t random_pixel();
    pixel_t px;
    px.hue        = ($urandom_range(1, 0) == 0) ? 17'($urandom_range(HUE_TURN - 1, 0))
                                                : 17'($urandom);
    px.saturation = ($urandom_range(4, 0) != 0) ? 10'($urandom_range(LEVEL_FULL, 0))
                                                : 10'($urandom);
    px.brightness = ($urandom_range(4, 0) != 0) ? 10'($urandom_range(LEVEL_FULL, 0))
                                                : 10'($urandom);
    return px;
  endfunction

  // Accept results with random stalls; stretches with ready held high
  initial begin : sink
    int stall;
    int taken;
    @(negedge rst);
    forever begin
      stall = ((taken / 150) % 3 == 2) ? 0 : $urandom_range(MAX_WAIT, 0);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_rgb(rgb_t'(m_tdata));
      taken++;
    end
  end

  initial begin : stimulus
    int k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // hue extremes and wrap points
    send_hsv(-65536, 256, 256);
    send_hsv(65535, 256, 256);
    send_hsv(-1, 256, 256);
    send_hsv(HUE_TURN, 256, 256);
    send_hsv(HUE_TURN - 1, 200, 180);
    // every sector: boundary and middle
    for (k = 0; k < 6; k++) begin
      send_hsv(k * SECTOR_SPAN, 256, 256);
      send_hsv(k * SECTOR_SPAN + 1920, 170, 230);
    end
    // clamping of levels
    send_hsv(1000, -512, 511);
    send_hsv(5000, 511, -512);
    send_hsv(9000, 257, 300);
    send_hsv(13000, -1, 255);
    // gray, including the exact-half rounding of brightness 128
    send_hsv(7777, 0, 128);
    send_hsv(-30000, 0, 1);
    send_hsv(0, 0, 0);
    directed_count = sent;

    for (k = 0; k < RANDOM_PIXELS; k++)
      send_pixel(random_pixel(), (k / 150) % 3 == 1);
    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain, then watch for stray beats
    while (tracker.expected_rgb.size() != 0) @(posedge clk);
    repeat (hsvr_pkg::NUM_STAGES + 10) @(posedge clk);

    $display("sent %0d pixels (%0d directed), checked %0d color beats, %0d mismatches",
             sent, directed_count, tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_rgb.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
